[rtl/ffsp_pkg.sv]
// ----------------------------------------------------------------------------
// ffsp_pkg
// Shared types and constants of the first-fit slice pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffsp_pkg;

  localparam int unsigned BLK_W  = 4;
  localparam int unsigned SIZE_W = 31;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 40;
  localparam int unsigned ALGN_W = 5;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 152;
  localparam int unsigned SLICE_W    = BLK_W + 2 * WORD_W;

  localparam logic REQ_RESERVE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic CFG_INIT_SIZE = 1'b0;
  localparam logic CFG_ALIGN     = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_TBL_FULL = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_NOFIT,
    S_MAKE,
    S_BUMP,
    S_FINISH
  } ffsp_state_t;

  typedef struct packed {
    logic load_req;
    logic rel_exec;
    logic set_reject;
    logic idx_clr;
    logic idx_inc;
    logic rd_next;
    logic hit_take;
    logic shift_wr;
    logic slice_dec;
    logic make_blk;
    logic bump_take;
    logic set_nospace;
    logic load_out;
  } ffsp_cmd_t;

  typedef struct packed {
    logic is_release;
    logic size_zero;
    logic scan_end;
    logic hit;
    logic rem_zero;
    logic shift_end;
    logic no_blocks;
    logic pool_full;
    logic bump_fit;
    logic out_free;
  } ffsp_stat_t;

endpackage
`default_nettype wire

[rtl/ffsp_ctrl.sv]
// ----------------------------------------------------------------------------
// ffsp_ctrl
// Sequencer that steps the datapath through release, scan, removal and block growth.
// ----------------------------------------------------------------------------
`default_nettype none
module ffsp_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_fire,
  input  ffsp_pkg::ffsp_stat_t stat,
  output logic                in_ready,
  output ffsp_pkg::ffsp_cmd_t cmd
);
  import ffsp_pkg::*;

  ffsp_state_t state, state_next;
  logic [1:0]  made, made_next;
  logic        first_empty, first_empty_next;
  logic [1:0]  limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      made        <= 2'd0;
      first_empty <= 1'b0;
    end else begin
      state       <= state_next;
      made        <= made_next;
      first_empty <= first_empty_next;
    end
  end

  assign limit = first_empty ? 2'd2 : 2'd1;

  always_comb begin
    state_next       = state;
    made_next        = made;
    first_empty_next = first_empty;
    cmd              = '0;
    in_ready         = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_req = 1'b1;
          made_next    = 2'd0;
          state_next   = S_START;
        end
      end
      S_START: begin
        if (stat.is_release) begin
          cmd.rel_exec = 1'b1;
          state_next   = S_FINISH;
        end else if (stat.size_zero) begin
          cmd.set_reject = 1'b1;
          state_next     = S_FINISH;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = stat.scan_end ? S_NOFIT : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.hit) begin
          cmd.hit_take = 1'b1;
          state_next   = stat.rem_zero ? S_SHIFT_RD : S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.shift_end) begin
          cmd.slice_dec = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_NOFIT: begin
        first_empty_next = stat.no_blocks;
        state_next       = stat.no_blocks ? S_MAKE : S_BUMP;
      end
      S_MAKE: begin
        if (stat.pool_full) begin
          cmd.set_nospace = 1'b1;
          state_next      = S_FINISH;
        end else begin
          cmd.make_blk = 1'b1;
          made_next    = made + 2'd1;
          state_next   = S_BUMP;
        end
      end
      S_BUMP: begin
        if (stat.bump_fit) begin
          cmd.bump_take = 1'b1;
          state_next    = S_FINISH;
        end else if (made == limit) begin
          cmd.set_nospace = 1'b1;
          state_next      = S_FINISH;
        end else begin
          state_next = S_MAKE;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/ffsp_datapath.sv]
// ----------------------------------------------------------------------------
// ffsp_datapath
// Block and slice tables, alignment arithmetic, byte counters and result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module ffsp_datapath #(
  parameter int unsigned MAX_BLOCKS      = 16,
  parameter int unsigned MAX_FREE_SLICES = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire                                  cfg_addr,
  input  wire  [ffsp_pkg::WORD_W-1:0]          cfg_wdata,
  input  wire  [ffsp_pkg::IN_DATA_W-1:0]       in_data,
  input  wire                                  in_user,
  input  ffsp_pkg::ffsp_cmd_t                  cmd,
  output ffsp_pkg::ffsp_stat_t                 stat,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [ffsp_pkg::OUT_DATA_W-1:0]      out_data
);
  import ffsp_pkg::*;

  localparam int unsigned BCW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned BIW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned SCW = $clog2(MAX_FREE_SLICES + 1);
  localparam int unsigned SAW = (MAX_FREE_SLICES > 1) ? $clog2(MAX_FREE_SLICES) : 1;

  logic [WORD_W-1:0] init_size;
  logic [ALGN_W-1:0] align_log2;

  logic              req_kind;
  logic [SIZE_W-1:0] req_size;
  logic [BLK_W-1:0]  req_blk;
  logic [WORD_W-1:0] req_off;
  logic [WORD_W-1:0] req_rsv;

  logic [WORD_W-1:0] blk_cap [MAX_BLOCKS];
  logic [WORD_W-1:0] blk_used [MAX_BLOCKS];
  logic [BCW-1:0]    block_count;

  logic [SLICE_W-1:0] slice_mem [MAX_FREE_SLICES];
  logic [SLICE_W-1:0] rd_data;
  logic [SCW-1:0]     slice_count;
  logic [SCW-1:0]     idx;

  logic [BYTE_W-1:0] bytes_active;
  logic [BYTE_W-1:0] bytes_peak;

  logic [STAT_W-1:0] res_status;
  logic [BLK_W-1:0]  res_blk;
  logic [WORD_W-1:0] res_off;
  logic [WORD_W-1:0] res_rsv;

  logic [33:0] amask;
  logic [32:0] rsv_ext;
  logic [WORD_W-1:0] rsv;
  logic [BIW-1:0] last;
  logic [BIW-1:0] fresh;
  logic [WORD_W-1:0] cap_last;
  logic [33:0] bump_off;
  logic [33:0] bump_room;
  logic [32:0] grow;
  logic [32:0] need;
  logic [33:0] cap_al;
  logic [WORD_W-1:0] cap_new;
  logic [BLK_W-1:0]  rd_blk;
  logic [WORD_W-1:0] rd_off;
  logic [WORD_W-1:0] rd_size;
  logic [WORD_W-1:0] rem;
  logic [BYTE_W:0]   acc_sum;
  logic [BYTE_W-1:0] acc_val;
  logic              rel_bad;
  logic              rel_full;
  logic [SAW-1:0]    rd_addr;
  logic              mem_we;
  logic [SAW-1:0]    wr_addr;
  logic [SLICE_W-1:0] wr_data;
  logic [SCW-1:0]    idx_p1;

  assign amask   = (34'd1 << align_log2) - 34'd1;
  assign rsv_ext = (33'(req_size) + amask[32:0]) & ~amask[32:0];
  assign rsv     = rsv_ext[WORD_W-1:0];

  assign last     = BIW'(block_count - BCW'(1));
  assign fresh    = BIW'(block_count);
  assign cap_last = blk_cap[last];
  assign bump_off = (34'(blk_used[last]) + amask) & ~amask;
  assign bump_room = 34'(cap_last) - bump_off;
  assign grow     = (block_count == '0) ? 33'(init_size) : {cap_last, 1'b0};
  assign need     = (33'(rsv) > grow) ? 33'(rsv) : grow;
  assign cap_al   = (34'(need) + amask) & ~amask;
  assign cap_new  = (cap_al > 34'h0_FFFF_FFFF) ? WORD_W'(34'h1_0000_0000 - (amask + 34'd1))
                                               : cap_al[WORD_W-1:0];

  assign rd_blk  = rd_data[BLK_W-1:0];
  assign rd_off  = rd_data[BLK_W +: WORD_W];
  assign rd_size = rd_data[BLK_W+WORD_W +: WORD_W];
  assign rem     = rd_size - rsv;

  assign acc_sum = {1'b0, bytes_active} + (BYTE_W+1)'(rsv);
  assign acc_val = acc_sum[BYTE_W] ? {BYTE_W{1'b1}} : acc_sum[BYTE_W-1:0];

  assign rel_bad  = (32'(req_blk) >= 32'(block_count)) || (req_rsv == '0);
  assign rel_full = (slice_count == SCW'(MAX_FREE_SLICES));

  assign idx_p1  = idx + SCW'(1);
  assign rd_addr = cmd.rd_next ? SAW'(idx_p1) : SAW'(idx);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = SAW'(idx);
    wr_data = rd_data;
    if (cmd.rel_exec && !rel_bad && !rel_full) begin
      mem_we  = 1'b1;
      wr_addr = SAW'(slice_count);
      wr_data = {req_rsv, req_off, req_blk};
    end else if (cmd.hit_take && rem != '0) begin
      mem_we  = 1'b1;
      wr_data = {rem, rd_off + rsv, rd_blk};
    end else if (cmd.shift_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slice_mem[wr_addr] <= wr_data;
    end
    rd_data <= slice_mem[rd_addr];
  end

  always_comb begin
    stat.is_release = (req_kind == REQ_RELEASE);
    stat.size_zero  = (req_size == '0);
    stat.scan_end   = (idx >= slice_count) || (idx >= SCW'(MAX_FREE_SLICES));
    stat.hit        = (rd_size >= rsv) && (32'(rd_blk) < 32'(block_count));
    stat.rem_zero   = (rem == '0);
    stat.shift_end  = (idx_p1 >= slice_count);
    stat.no_blocks  = (block_count == '0);
    stat.pool_full  = (block_count == BCW'(MAX_BLOCKS));
    stat.bump_fit   = (bump_off <= 34'(cap_last)) && (34'(req_size) <= bump_room);
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.make_blk) begin
      blk_cap[fresh]  <= cap_new;
      blk_used[fresh] <= '0;
    end else if (cmd.bump_take) begin
      blk_used[last] <= WORD_W'(bump_off + 34'(req_size));
    end
    if (cmd.load_req) begin
      req_kind <= in_user;
      req_size <= in_data[30:0];
      req_blk  <= in_data[34:31];
      req_off  <= in_data[66:35];
      req_rsv  <= in_data[98:67];
      res_status <= ST_OK;
      res_blk    <= '0;
      res_off    <= '0;
      res_rsv    <= '0;
    end
    if (cmd.set_reject) begin
      res_status <= ST_REJECT;
    end
    if (cmd.set_nospace) begin
      res_status <= ST_NO_SPACE;
    end
    if (cmd.rel_exec) begin
      if (rel_bad) begin
        res_status <= ST_REJECT;
      end else if (rel_full) begin
        res_status <= ST_TBL_FULL;
      end
    end
    if (cmd.hit_take) begin
      res_blk <= rd_blk;
      res_off <= rd_off;
      res_rsv <= rsv;
    end
    if (cmd.bump_take) begin
      res_blk <= BLK_W'(last);
      res_off <= bump_off[WORD_W-1:0];
      res_rsv <= rsv;
    end
    if (cmd.load_out) begin
      out_data <= {2'b00, bytes_peak, bytes_active, res_rsv, res_off, res_blk, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_size    <= 32'd262144;
      align_log2   <= 5'd8;
      block_count  <= '0;
      slice_count  <= '0;
      idx          <= '0;
      bytes_active <= '0;
      bytes_peak   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_INIT_SIZE: init_size  <= cfg_wdata;
          CFG_ALIGN:     align_log2 <= cfg_wdata[ALGN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.make_blk) begin
        block_count <= block_count + BCW'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx_p1;
      end
      if (cmd.slice_dec) begin
        slice_count <= slice_count - SCW'(1);
      end
      if (cmd.rel_exec && !rel_bad && !rel_full) begin
        slice_count  <= slice_count + SCW'(1);
        bytes_active <= (BYTE_W'(req_rsv) <= bytes_active) ?
                        bytes_active - BYTE_W'(req_rsv) : '0;
      end
      if (cmd.hit_take || cmd.bump_take) begin
        bytes_active <= acc_val;
        if (acc_val > bytes_peak) begin
          bytes_peak <= acc_val;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/first_fit_slice_pool_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_slice_pool_allocator
// Reserve and release requests against a pool of blocks and a free-slice table.
// ----------------------------------------------------------------------------
// One request is handled at a time. A reserve scans the free-slice table entry
// by entry through the registered read port of the slice memory; removing an
// emptied slice shifts the rest of the table down entry by entry, and a miss
// goes on to bump allocation and block creation. The result beat sits in an
// output register, so the next request is taken while a result still waits.
`default_nettype none
module first_fit_slice_pool_allocator #(
  parameter int unsigned MAX_BLOCKS      = 16,
  parameter int unsigned MAX_FREE_SLICES = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire          cfg_addr,
  input  wire  [31:0]  cfg_wdata,
  input  wire          s_tvalid,
  output logic         s_tready,
  // request_size, release_block, release_offset, release_reserved_size
  input  wire  [103:0] s_tdata,
  // req_type
  input  wire          s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // status, block_index, offset, reserved_size, active_bytes, high_watermark
  output logic [151:0] m_tdata
);
  import ffsp_pkg::*;

  ffsp_cmd_t  cmd;
  ffsp_stat_t stat;

  ffsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_tvalid && s_tready),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  ffsp_datapath #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_FREE_SLICES (MAX_FREE_SLICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

[tb/sv/first_fit_slice_pool_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_slice_pool_allocator_test
// Self-checking testbench of the first-fit slice pool allocator.
// ----------------------------------------------------------------------------
// A directed opening covers zero requests, the largest sizes, bad and bogus
// releases and wrapping slice offsets. Random traffic then runs under several
// register settings, mostly reserves and releases of live reservations. The
// run closes by filling the free table and the block pool. A local allocator
// model predicts every result beat, and the results are checked in order.
// ----------------------------------------------------------------------------
module first_fit_slice_pool_allocator_test;
  import ffsp_pkg::*;

  localparam logic [63:0] M32 = 64'hFFFF_FFFF;
  localparam logic [63:0] M40 = 64'hFF_FFFF_FFFF;
  localparam int NBLK = 16;
  localparam int NSLC = 32;

  typedef struct {
    logic        kind;
    logic [30:0] size;
    logic [3:0]  blk;
    logic [31:0] off;
    logic [31:0] rsz;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  blk;
    logic [31:0] off;
    logic [31:0] rsv;
    logic [39:0] act;
    logic [39:0] peak;
  } res_t;

  typedef struct {
    logic [3:0]  blk;
    logic [31:0] off;
    logic [31:0] rsv;
  } grant_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;

  first_fit_slice_pool_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t   pending[$];
  res_t   expected_results[$];
  grant_t live_grants[$];
  int     errors = 0;
  logic   accepted_q = 1'b0;
  logic   calm = 1'b0;
  logic   hold_req = 1'b0;
  int     hold_cnt = 0;

  // Allocator state as predicted.
  logic [63:0] blk_cap[NBLK];
  logic [63:0] blk_used[NBLK];
  int          blk_cnt = 0;
  logic [63:0] fs_blk[NSLC];
  logic [63:0] fs_off[NSLC];
  logic [63:0] fs_size[NSLC];
  int          fs_cnt = 0;
  logic [63:0] live_bytes = '0;
  logic [63:0] peak_bytes = '0;
  logic [63:0] init_size = 64'd262144;
  logic [4:0]  align_log = 5'd8;

  function automatic logic [63:0] round_up(logic [63:0] v, logic [63:0] a);
    return (v + a - 64'd1) & ~(a - 64'd1);
  endfunction

  function automatic bit grow_pool(logic [63:0] need, logic [63:0] a);
    logic [63:0] grow;
    logic [63:0] cap;
    if (blk_cnt >= NBLK) return 1'b0;
    grow = (blk_cnt == 0) ? init_size : blk_cap[blk_cnt-1] * 2;
    cap = round_up((need > grow) ? need : grow, a);
    if (cap > M32) cap = (M32 + 64'd1) - a;
    blk_cap[blk_cnt] = cap;
    blk_used[blk_cnt] = '0;
    blk_cnt++;
    return 1'b1;
  endfunction

  function automatic bit bump_last(logic [63:0] size, logic [63:0] a, output logic [63:0] off);
    logic [63:0] o;
    logic [63:0] cap;
    o = round_up(blk_used[blk_cnt-1], a);
    cap = blk_cap[blk_cnt-1];
    off = '0;
    if (o > cap || size > cap - o) return 1'b0;
    blk_used[blk_cnt-1] = o + size;
    off = o;
    return 1'b1;
  endfunction

  function automatic res_t allocate(req_t rq);
    res_t        r;
    logic [63:0] a;
    logic [63:0] need;
    logic [63:0] off;
    logic [63:0] s;
    bit          done;
    r = '{ST_OK, '0, '0, '0, '0, '0};
    done = 1'b0;
    off = '0;
    if (rq.kind == REQ_RESERVE) begin
      a = 64'd1 << align_log;
      if (rq.size == 0) begin
        r.status = ST_REJECT;
      end else begin
        need = round_up(64'(rq.size), a);
        for (int i = 0; i < fs_cnt; i++) begin
          if (fs_size[i] < need || fs_blk[i] >= blk_cnt) continue;
          r.blk = fs_blk[i][3:0];
          off = fs_off[i];
          fs_off[i] = (fs_off[i] + need) & M32;
          fs_size[i] = fs_size[i] - need;
          if (fs_size[i] == 0) begin
            for (int j = i; j < fs_cnt - 1; j++) begin
              fs_blk[j] = fs_blk[j+1];
              fs_off[j] = fs_off[j+1];
              fs_size[j] = fs_size[j+1];
            end
            fs_cnt--;
          end
          done = 1'b1;
          break;
        end
        if (!done) begin
          if (blk_cnt == 0 && !grow_pool(need, a)) r.status = ST_NO_SPACE;
          else if (bump_last(64'(rq.size), a, off)) done = 1'b1;
          else if (!grow_pool(need, a)) r.status = ST_NO_SPACE;
          else begin
            done = bump_last(64'(rq.size), a, off);
            if (!done) r.status = ST_NO_SPACE;
          end
          if (done) r.blk = 4'(blk_cnt - 1);
        end
        if (done) begin
          r.off = off[31:0];
          r.rsv = need[31:0];
          s = live_bytes + need;
          live_bytes = (s > M40) ? M40 : s;
          if (live_bytes > peak_bytes) peak_bytes = live_bytes;
          live_grants.insert(live_grants.size(), '{r.blk, r.off, r.rsv});
        end else begin
          r.blk = '0;
          r.off = '0;
        end
      end
    end else begin
      if (rq.blk >= blk_cnt || rq.rsz == 0) begin
        r.status = ST_REJECT;
      end else if (fs_cnt >= NSLC) begin
        r.status = ST_TBL_FULL;
      end else begin
        fs_blk[fs_cnt] = 64'(rq.blk);
        fs_off[fs_cnt] = 64'(rq.off);
        fs_size[fs_cnt] = 64'(rq.rsz);
        fs_cnt++;
        live_bytes = (64'(rq.rsz) <= live_bytes) ? live_bytes - 64'(rq.rsz) : '0;
      end
    end
    r.act = live_bytes[39:0];
    r.peak = peak_bytes[39:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t exp;
    accepted_q <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
                                allocate('{s_tuser, s_tdata[30:0], s_tdata[34:31],
                                           s_tdata[66:35], s_tdata[98:67]}));
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[1:0], m_tdata[5:2], m_tdata[37:6], m_tdata[69:38],
                m_tdata[109:70], m_tdata[149:110]};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat %p", $time, got);
          errors++;
        end else begin
          exp = expected_results.pop_front();
          if (got.status !== exp.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
            errors++;
          end
          if (got.blk !== exp.blk) begin
            $display("%0t: block_index exp %0d got %0d", $time, exp.blk, got.blk);
            errors++;
          end
          if (got.off !== exp.off) begin
            $display("%0t: offset exp %0h got %0h", $time, exp.off, got.off);
            errors++;
          end
          if (got.rsv !== exp.rsv) begin
            $display("%0t: reserved_size exp %0h got %0h", $time, exp.rsv, got.rsv);
            errors++;
          end
          if (got.act !== exp.act) begin
            $display("%0t: active_bytes exp %0h got %0h", $time, exp.act, got.act);
            errors++;
          end
          if (got.peak !== exp.peak) begin
            $display("%0t: high_watermark exp %0h got %0h", $time, exp.peak, got.peak);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    req_t rq;
    if (!s_tvalid || accepted_q) begin
      if (!rst && pending.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
        rq = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= rq.kind;
        s_tdata <= {5'b0, rq.rsz, rq.off, rq.blk, rq.size};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && hold_cnt < 300) begin
      hold_cnt <= hold_cnt + 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && (calm || $urandom_range(99) >= 38);
    end
  end

  task automatic add_reserve(logic [30:0] size);
    pending.insert(pending.size(), '{REQ_RESERVE, size, '0, '0, '0});
  endtask

  task automatic add_release(logic [3:0] b, logic [31:0] o, logic [31:0] s);
    pending.insert(pending.size(), '{REQ_RELEASE, '0, b, o, s});
  endtask

  task automatic drain();
    while (pending.size() > 0 || s_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == CFG_INIT_SIZE) init_size = 64'(val);
    else align_log = val[4:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(int n);
    grant_t g;
    int     k;
    int     pick;
    for (int i = 0; i < n; i++) begin
      while (pending.size() >= 2) @(posedge clk);
      pick = $urandom_range(99);
      if (pick < 55) begin
        k = $urandom_range(99);
        if (k < 4) add_reserve('0);
        else if (k < 12) add_reserve(31'($urandom));
        else add_reserve(31'($urandom_range(1, 6000)));
      end else if (pick < 88 && live_grants.size() > 0) begin
        k = $urandom_range(live_grants.size() - 1);
        g = live_grants[k];
        live_grants.delete(k);
        add_release(g.blk, g.off, g.rsv);
      end else begin
        add_release(4'($urandom), $urandom,
                    ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 4096)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_reserve('0);
    add_release(4'd0, 32'd0, 32'd256);
    add_reserve(31'd1);
    add_reserve(31'd300);
    add_release(4'd0, 32'd0, 32'd0);
    add_release(4'd15, 32'd0, 32'd512);
    add_release(4'd0, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    add_reserve(31'd512);
    add_reserve(31'd256);
    add_reserve(31'h7FFF_FFFF);
    add_reserve(31'h7FFF_FFFF);
    add_release(4'd1, 32'd0, 32'h8000_0000);
    add_reserve(31'h4000_0000);
    add_reserve(31'd100);
    drain();

    random_traffic(200);
    drain();

    write_reg(CFG_INIT_SIZE, 32'd1);
    write_reg(CFG_ALIGN, 32'd0);
    calm = 1'b1;
    random_traffic(150);
    drain();
    calm = 1'b0;

    write_reg(CFG_INIT_SIZE, 32'h8000_0000);
    write_reg(CFG_ALIGN, 32'd16);
    hold_req = 1'b1;
    random_traffic(150);
    drain();

    write_reg(CFG_INIT_SIZE, 32'd4096);
    write_reg(CFG_ALIGN, 32'd31 & 32'd21);
    write_reg(CFG_ALIGN, 32'd4);
    random_traffic(200);
    drain();

    for (int i = 0; i < 34; i++) add_release(4'd0, $urandom, 32'd1);
    for (int i = 0; i < 20; i++) add_reserve(31'h7FFF_FFFF);
    drain();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule
